@@ hw/rtl/mid_pkg.sv @@
package mid_pkg;

    localparam int IntervalWidth = 16;
    localparam int ByteWidth     = 8;
    localparam int CountWidth    = 3;

    localparam logic [IntervalWidth-1:0] TIMEOUT_RESET = 16'd1000;

    // Decoder state carried from one interval to the next.
    typedef struct packed {
        logic                     sync_pending;
        logic [IntervalWidth-1:0] period_estimate;
        logic                     at_midpoint;
        logic [ByteWidth-1:0]     shift_bits;
        logic [CountWidth-1:0]    bit_count;
    } mid_state_t;

    localparam mid_state_t STATE_RESET = '{
        sync_pending:    1'b1,
        period_estimate: '0,
        at_midpoint:     1'b0,
        shift_bits:      '0,
        bit_count:       '0
    };

    // What one interval produces besides the next state.
    typedef struct packed {
        logic                 byte_vld;
        logic [ByteWidth-1:0] data_byte;
    } mid_result_t;

endpackage

@@ hw/rtl/manchester_interval_decoder.sv @@
// Decodes a Manchester line from the measured times between its edges. Each
// transfer on the s_ channel carries one edge-to-edge interval in microseconds;
// every eighth decoded bit produces one byte on the m_ channel, first bit in
// the most significant position. An interval above cfg_timeout_us drops sync
// and discards any partial byte. The block takes one interval per clock cycle
// as long as results are taken; an interval passes an input register and the
// decode logic, and its byte is then written into the result register. A held
// result stalls only intervals that complete a byte.
module manchester_interval_decoder
    import mid_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [IntervalWidth-1:0] cfg_timeout_us,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [IntervalWidth-1:0] s_interval_us,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [ByteWidth-1:0]     m_data_byte
);

    logic [IntervalWidth-1:0] timeout_reg;
    logic                     in_vld_reg;
    logic [IntervalWidth-1:0] in_interval_reg;
    mid_state_t               state_reg;
    mid_state_t               state_next;
    mid_result_t              step_result;
    logic                     out_vld_reg;
    logic [ByteWidth-1:0]     out_byte_reg;
    logic                     out_free;
    logic                     proc_fire;

    mid_step u_step (
        .state       (state_reg),
        .interval_us (in_interval_reg),
        .timeout_us  (timeout_reg),
        .state_next  (state_next),
        .result      (step_result)
    );

    assign cfg_ready = 1'b1;
    assign out_free  = !out_vld_reg || m_ready;
    // The held interval is decoded once there is room for any byte it yields.
    assign proc_fire = in_vld_reg && (!step_result.byte_vld || out_free);
    assign s_ready   = !in_vld_reg || proc_fire;

    assign m_valid     = out_vld_reg;
    assign m_data_byte = out_byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            timeout_reg <= cfg_timeout_us;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_interval_reg <= s_interval_us;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (proc_fire) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (proc_fire && step_result.byte_vld) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && step_result.byte_vld) begin
            out_byte_reg <= step_result.data_byte;
        end
    end

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !in_vld_reg && !out_vld_reg)
        else $error("pipeline not empty after reset");

    a_stall_means_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_vld_reg && !out_free)
        else $error("input stalled without a held interval and a blocked result");

    a_byte_clears_assembler: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && step_result.byte_vld
        |=> m_valid && state_reg.bit_count == '0 && state_reg.shift_bits == '0)
        else $error("completed byte did not reach the output or clear the assembler");

    a_timeout_drops_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && (in_interval_reg > timeout_reg)
        |=> state_reg.sync_pending && state_reg.bit_count == '0
            && !m_valid == $past(!m_valid || m_ready))
        else $error("interval above timeout did not drop sync");

endmodule

@@ hw/rtl/mid_step.sv @@
module mid_step
    import mid_pkg::*;
(
    input  mid_state_t               state,
    input  logic [IntervalWidth-1:0] interval_us,
    input  logic [IntervalWidth-1:0] timeout_us,
    output mid_state_t               state_next,
    output mid_result_t              result
);

    logic [IntervalWidth:0]   threshold;
    logic [IntervalWidth:0]   short_sum;
    logic [IntervalWidth+1:0] long_sum;
    logic                     push;
    logic                     push_bit;
    logic [ByteWidth-1:0]     shifted;
    logic [CountWidth-1:0]    count_inc;

    // The threshold is 1.5 times the estimate, kept at 17 bits so it never wraps.
    assign threshold = {1'b0, state.period_estimate}
                     + {2'b00, state.period_estimate[IntervalWidth-1:1]};
    assign short_sum = {1'b0, state.period_estimate} + {1'b0, interval_us};
    assign long_sum  = {1'b0, state.period_estimate, 1'b0} + {2'b00, interval_us};

    assign shifted   = {state.shift_bits[ByteWidth-2:0], push_bit};
    assign count_inc = state.bit_count + CountWidth'(1);

    always_comb begin
        state_next = state;
        push       = 1'b0;
        push_bit   = 1'b0;
        result     = '0;

        if (interval_us > timeout_us) begin
            state_next.sync_pending = 1'b1;
            state_next.shift_bits   = '0;
            state_next.bit_count    = '0;
        end else if (state.sync_pending) begin
            state_next.period_estimate = interval_us;
            state_next.at_midpoint     = 1'b1;
            state_next.sync_pending    = 1'b0;
        end else if ({1'b0, interval_us} < threshold) begin
            // Short interval: a bit is complete only on the second half-bit edge.
            if (state.at_midpoint) begin
                state_next.at_midpoint = 1'b0;
                push                   = 1'b1;
                push_bit               = 1'b1;
            end else begin
                state_next.at_midpoint = 1'b1;
            end
            state_next.period_estimate = short_sum[IntervalWidth:1];
        end else begin
            push                       = 1'b1;
            push_bit                   = 1'b0;
            state_next.period_estimate = long_sum[IntervalWidth+1:2];
        end

        if (push) begin
            state_next.bit_count = count_inc;
            if (count_inc == '0) begin
                result.byte_vld       = 1'b1;
                result.data_byte      = shifted;
                state_next.shift_bits = '0;
            end else begin
                state_next.shift_bits = shifted;
            end
        end
    end

endmodule
